// ===== hw/rtl/mlc_pkg.sv =====
// Shared types, constants and helpers for the midpoint line clipper.
`timescale 1ns / 1ps

package mlc_pkg;

  localparam int COORD_BITS  = 16;
  localparam int CW          = COORD_BITS + 2;   // room for left + width and last column
  localparam int SIZE_BITS   = COORD_BITS - 1;
  localparam int COLOUR_BITS = 32;
  localparam int BISECT_CAP  = 96;
  localparam int CNT_W       = $clog2(BISECT_CAP + 1);
  localparam int CFG_IDX_W   = 4;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [CW-1:0]         wcoord_t;
  typedef logic [SIZE_BITS-1:0]         size_t;
  typedef logic [COLOUR_BITS-1:0]       colour_t;
  typedef logic [CNT_W-1:0]             step_cnt_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_VIEW_LEFT   = 4'd0,
    REG_VIEW_TOP    = 4'd1,
    REG_VIEW_WIDTH  = 4'd2,
    REG_VIEW_HEIGHT = 4'd3
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETUP,
    ST_SCREEN,
    ST_RIGHT,
    ST_TOP_START,
    ST_TOP,
    ST_CHECK,
    ST_EMIT
  } seq_state_t;

  typedef struct packed {
    coord_t left;
    coord_t top;
    size_t  width;
    size_t  height;
  } view_cfg_t;

  typedef struct packed {
    coord_t  sx;
    coord_t  sy;
    coord_t  ex;
    coord_t  ey;
    colour_t colour;
  } seg_t;

  // operands for the midpoint unit
  typedef struct packed {
    wcoord_t ax;
    wcoord_t bx;
    wcoord_t ay;
    wcoord_t by;
    wcoord_t limit;
    logic    on_y;
  } mid_req_t;

  typedef struct packed {
    wcoord_t mx;
    wcoord_t my;
    logic    hit;
  } mid_rsp_t;

  function automatic wcoord_t widen(coord_t v);
    return {{(CW-COORD_BITS){v[COORD_BITS-1]}}, v};
  endfunction

  function automatic wcoord_t widen_size(size_t v);
    return {{(CW-SIZE_BITS){1'b0}}, v};
  endfunction

  // floor((a + b) / 2): one bit of extra range, then drop the low bit
  function automatic wcoord_t floor_mid(wcoord_t a, wcoord_t b);
    logic signed [CW:0] s;
    s = {a[CW-1], a} + {b[CW-1], b};
    return s[CW:1];
  endfunction

endpackage

// ===== hw/rtl/mlc_mid_unit.sv =====
// Shared midpoint unit: halves both coordinate pairs and compares against a limit.
`timescale 1ns / 1ps

module mlc_mid_unit import mlc_pkg::*; (
  input  mid_req_t req,
  output mid_rsp_t rsp
);

  wcoord_t mx;
  wcoord_t my;

  always_comb begin
    mx      = floor_mid(req.ax, req.bx);
    my      = floor_mid(req.ay, req.by);
    rsp.mx  = mx;
    rsp.my  = my;
    // top edge: inner side is below; right edge: outer side is at or past it
    rsp.hit = req.on_y ? (my <= $signed(req.limit)) : (mx >= $signed(req.limit));
  end

endmodule

// ===== hw/rtl/mlc_seq.sv =====
// Clipping sequencer: screens a segment and runs both bisection loops on the midpoint unit.
`timescale 1ns / 1ps

module mlc_seq import mlc_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  view_cfg_t cfg,
  input  logic      in_valid,
  output logic      in_stall,
  input  seg_t      seg_in,
  output logic      res_valid,
  input  logic      res_take,
  output seg_t      res
);

  seq_state_t state, state_next;
  wcoord_t    sx, sx_next, sy, sy_next, ex, ex_next, ey, ey_next;
  wcoord_t    ix, ix_next, iy, iy_next;
  wcoord_t    right, right_next, last_col, last_col_next, bottom, bottom_next;
  colour_t    colour, colour_next;
  step_cnt_t  cnt, cnt_next;
  mid_req_t   req;
  mid_rsp_t   rsp;
  wcoord_t    left_w, top_w;
  logic       in_view;

  assign left_w = widen(cfg.left);
  assign top_w  = widen(cfg.top);

  mlc_mid_unit u_mid (
    .req (req),
    .rsp (rsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    sx       <= sx_next;
    sy       <= sy_next;
    ex       <= ex_next;
    ey       <= ey_next;
    ix       <= ix_next;
    iy       <= iy_next;
    right    <= right_next;
    last_col <= last_col_next;
    bottom   <= bottom_next;
    colour   <= colour_next;
    cnt      <= cnt_next;
  end

  always_comb begin
    in_view = (sy >= top_w) && (ey >= top_w) && (sx >= left_w) && (ex >= left_w) &&
              (sy < bottom) && (ey < bottom) && (sx < right) && (ex < right);
  end

  always_comb begin
    state_next    = state;
    sx_next       = sx;
    sy_next       = sy;
    ex_next       = ex;
    ey_next       = ey;
    ix_next       = ix;
    iy_next       = iy;
    right_next    = right;
    last_col_next = last_col;
    bottom_next   = bottom;
    colour_next   = colour;
    cnt_next      = cnt;

    req.ax    = ix;
    req.bx    = ex;
    req.ay    = iy;
    req.by    = ey;
    req.on_y  = (state == ST_TOP);
    req.limit = (state == ST_TOP) ? top_w : last_col;

    in_stall   = (state != ST_IDLE);
    res_valid  = (state == ST_EMIT);
    res.sx     = sx[COORD_BITS-1:0];
    res.sy     = sy[COORD_BITS-1:0];
    res.ex     = ex[COORD_BITS-1:0];
    res.ey     = ey[COORD_BITS-1:0];
    res.colour = colour;

    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          sx_next     = widen(seg_in.sx);
          sy_next     = widen(seg_in.sy);
          ex_next     = widen(seg_in.ex);
          ey_next     = widen(seg_in.ey);
          colour_next = seg_in.colour;
          state_next  = ST_SETUP;
        end
      end
      ST_SETUP: begin
        right_next  = left_w + widen_size(cfg.width);
        bottom_next = top_w + widen_size(cfg.height);
        state_next  = ST_SCREEN;
      end
      ST_SCREEN: begin
        last_col_next = right - wcoord_t'(1);
        if ((sx >= right && ex >= right) || (sy < top_w && ey < top_w)) begin
          state_next = ST_IDLE;
        end else if (ex >= right) begin
          ix_next    = sx;
          iy_next    = sy;
          cnt_next   = '0;
          state_next = ST_RIGHT;
        end else begin
          state_next = ST_TOP_START;
        end
      end
      ST_RIGHT: begin
        if (ex == last_col) begin
          state_next = ST_TOP_START;
        end else if (cnt >= step_cnt_t'(BISECT_CAP)) begin
          ex_next    = ix;
          ey_next    = iy;
          state_next = ST_TOP_START;
        end else begin
          cnt_next = cnt + step_cnt_t'(1);
          if (rsp.hit) begin
            ex_next = rsp.mx;
            ey_next = rsp.my;
          end else begin
            ix_next = rsp.mx;
            iy_next = rsp.my;
          end
        end
      end
      ST_TOP_START: begin
        if (ey < top_w) begin
          ix_next    = sx;
          iy_next    = sy;
          cnt_next   = '0;
          state_next = ST_TOP;
        end else begin
          state_next = ST_CHECK;
        end
      end
      ST_TOP: begin
        if (ey == top_w) begin
          state_next = ST_CHECK;
        end else if (cnt >= step_cnt_t'(BISECT_CAP)) begin
          ex_next    = ix;
          ey_next    = iy;
          state_next = ST_CHECK;
        end else begin
          cnt_next = cnt + step_cnt_t'(1);
          if (rsp.hit) begin
            // outer point moves in; no progress means take the inner point
            if (rsp.my == ey) begin
              ex_next    = ix;
              ey_next    = iy;
              state_next = ST_CHECK;
            end else begin
              ex_next = rsp.mx;
              ey_next = rsp.my;
            end
          end else begin
            ix_next = rsp.mx;
            iy_next = rsp.my;
            if (rsp.my == iy) begin
              ex_next    = rsp.mx;
              ey_next    = iy;
              state_next = ST_CHECK;
            end
          end
        end
      end
      ST_CHECK: begin
        state_next = in_view ? ST_EMIT : ST_IDLE;
      end
      ST_EMIT: begin
        if (res_take) begin
          state_next = ST_IDLE;
        end
      end
    endcase
  end

endmodule

// ===== hw/rtl/midpoint_line_clipper_core.sv =====
// Top level of the midpoint line clipper: view registers, sequencer and output register.
`timescale 1ns / 1ps

// Midpoint line clipper.
// Input channel (in_valid / in_stall): one segment per item, start point, end point
// and colour. An item is taken when in_valid is high and in_stall low. The block
// works on one segment at a time and holds in_stall high until it is done with it.
// Output channel (out_valid / out_stall): zero or one clipped segment per input item.
// The result sits in an output register, so the sequencer takes the next segment
// while a result still waits for the receiver; a held result only blocks the
// sequencer once it has a second result ready.
// Sequence: a segment rejected on screening frees the input after the setup and
// screening states. Otherwise setup and screening, then one bisection step per cycle
// on the shared midpoint unit for the right edge and then the top edge (never more
// than 96 steps each), and then the checks.
// Configuration (cfg_valid / cfg_ready / cfg_index / cfg_data): always ready; index 0
// view left, 1 view top, 2 view width, 3 view height; other indexes are ignored.
// Write it only while the block is idle.
// Reset (rst, synchronous): clears the view to zero, drops any result in flight and
// leaves the block ready for a segment.

module midpoint_line_clipper_core import mlc_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [COORD_BITS-1:0]  cfg_data,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  coord_t                 start_x,
  input  coord_t                 start_y,
  input  coord_t                 end_x,
  input  coord_t                 end_y,
  input  colour_t                line_colour,
  output logic                   out_valid,
  input  logic                   out_stall,
  output coord_t                 out_start_x,
  output coord_t                 out_start_y,
  output coord_t                 out_end_x,
  output coord_t                 out_end_y,
  output colour_t                out_colour
);

  view_cfg_t cfg;
  seg_t      seg_in;
  seg_t      res;
  seg_t      out_seg;
  logic      res_valid;
  logic      res_take;

  assign cfg_ready = 1'b1;

  // view registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_VIEW_LEFT:   cfg.left   <= cfg_data;
        REG_VIEW_TOP:    cfg.top    <= cfg_data;
        REG_VIEW_WIDTH:  cfg.width  <= cfg_data[SIZE_BITS-1:0];
        REG_VIEW_HEIGHT: cfg.height <= cfg_data[SIZE_BITS-1:0];
        default: begin
          // unknown register: drop the write
        end
      endcase
    end
  end

  assign seg_in.sx     = start_x;
  assign seg_in.sy     = start_y;
  assign seg_in.ex     = end_x;
  assign seg_in.ey     = end_y;
  assign seg_in.colour = line_colour;

  mlc_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .seg_in    (seg_in),
    .res_valid (res_valid),
    .res_take  (res_take),
    .res       (res)
  );

  // output register: take a new result when empty or when the current one leaves
  assign res_take = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_take) begin
      out_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take && res_valid) begin
      out_seg <= res;
    end
  end

  assign out_start_x = out_seg.sx;
  assign out_start_y = out_seg.sy;
  assign out_end_x   = out_seg.ex;
  assign out_end_y   = out_seg.ey;
  assign out_colour  = out_seg.colour;

  // a taken segment keeps the input closed for at least the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input open straight after accepting a segment");

  // a result handed over always lands in the output register
  a_result_lands: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_take |=> out_valid)
    else $error("handed-over result lost");

  // nothing appears on the output without a hand-over
  a_no_phantom: assert property (@(posedge clk) disable iff (rst)
    !out_valid && !(res_valid && res_take) |=> !out_valid)
    else $error("result appeared without a hand-over");

  // a delivered end point never lies above the top row or left of the view
  a_end_in_view: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_end_y >= cfg.top) && (out_end_x >= cfg.left))
    else $error("delivered end point outside the view");

endmodule

// ===== tb/tb_midpoint_line_clipper_core.sv =====
// Self-checking testbench for the midpoint line clipper core.
`timescale 1ns / 1ps

module tb_midpoint_line_clipper_core import mlc_pkg::*; ();

  localparam int PHASE_COUNT      = 9;
  localparam int PHASE_ITEMS      = 211;
  // Worst item: setup, two capped bisection loops and the checks.
  localparam int SETTLE_CYCLES    = 250;
  localparam int LONG_HOLD_CYCLES = 600;
  localparam int CYCLE_LIMIT      = 2000000;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [COORD_BITS-1:0] cfg_data  = '0;

  logic    in_valid    = 1'b0;
  logic    in_stall;
  coord_t  start_x     = '0;
  coord_t  start_y     = '0;
  coord_t  end_x       = '0;
  coord_t  end_y       = '0;
  colour_t line_colour = '0;

  logic    out_valid;
  logic    out_stall = 1'b0;
  coord_t  out_start_x;
  coord_t  out_start_y;
  coord_t  out_end_x;
  coord_t  out_end_y;
  colour_t out_colour;

  midpoint_line_clipper_core u_dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .start_x     (start_x),
    .start_y     (start_y),
    .end_x       (end_x),
    .end_y       (end_y),
    .line_colour (line_colour),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_start_x (out_start_x),
    .out_start_y (out_start_y),
    .out_end_x   (out_end_x),
    .out_end_y   (out_end_y),
    .out_colour  (out_colour)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Shadow copy of the view registers, updated on each accepted write.
  coord_t cur_left   = '0;
  coord_t cur_top    = '0;
  size_t  cur_width  = '0;
  size_t  cur_height = '0;

  seg_t pending_segs[$];      // items waiting to be offered
  seg_t clipped_expected[$];  // clipped segments still owed by the block
  seg_t offered_seg;
  seg_t predicted_seg;
  seg_t expected_seg;
  bit   holding = 1'b0;

  int segs_issued   = 0;
  int segs_taken    = 0;
  int err_count     = 0;
  int cycle_count   = 0;
  int send_idle_pct = 33;
  int recv_idle_pct = 56;

  bit long_hold_arm = 1'b0;
  int hold_count    = 0;

  // ---------------------------------------------------------------------------
  // Clipping prediction
  // ---------------------------------------------------------------------------

  // Floor of the average; int holds the sum of two widened coordinates easily.
  function automatic int half_sum_floor(int a, int b);
    return (a + b) >>> 1;
  endfunction

  // Clip the end point against the right edge, then the top edge, and say
  // whether the segment survives the final inside test.
  function automatic bit clip_segment(input seg_t s, output seg_t r);
    int sx, sy, ex, ey, right, last_col, top, ix, iy, m, old_iy, old_ey;
    sx = int'(s.sx);
    sy = int'(s.sy);
    ex = int'(s.ex);
    ey = int'(s.ey);
    right    = int'(cur_left) + int'(cur_width);
    last_col = right - 1;
    top      = int'(cur_top);
    r = s;

    // Screen out segments wholly right of or wholly above the view.
    if (sx >= right && ex >= right) return 1'b0;
    if (sy < top && ey < top) return 1'b0;

    if (ex >= right) begin
      ix = sx;
      iy = sy;
      for (int n = 0; ex != last_col; n++) begin
        if (n >= BISECT_CAP) begin
          ex = ix;
          ey = iy;
          break;
        end
        m = half_sum_floor(ix, ex);
        if (m >= last_col) begin
          ex = m;
          ey = half_sum_floor(iy, ey);
        end else begin
          ix = m;
          iy = half_sum_floor(iy, ey);
        end
      end
    end

    if (ey < top) begin
      ix = sx;
      iy = sy;
      for (int n = 0; ey != top; n++) begin
        old_iy = iy;
        old_ey = ey;
        if (n >= BISECT_CAP) begin
          ex = ix;
          ey = iy;
          break;
        end
        m = half_sum_floor(iy, ey);
        if (m <= top) begin
          ey = m;
          ex = half_sum_floor(ix, ex);
        end else begin
          iy = m;
          ix = half_sum_floor(ix, ex);
        end
        // No progress on either side: fall back to the inner point.
        if (iy == old_iy && ey == old_ey) begin
          ex = ix;
          ey = iy;
          break;
        end
      end
    end

    if (sy < top || ey < top) return 1'b0;
    if (sx < int'(cur_left) || ex < int'(cur_left)) return 1'b0;
    if (sy >= top + int'(cur_height) || ey >= top + int'(cur_height)) return 1'b0;
    if (sx >= right || ex >= right) return 1'b0;

    r.ex = coord_t'(ex);
    r.ey = coord_t'(ey);
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic int clamp_coord(int v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  // Uniform pick from [lo, lo + span), or lo when the span is empty.
  function automatic int pick_in(int lo, int span);
    if (span <= 0) return lo;
    return lo + int'($urandom_range(span - 1));
  endfunction

  // Distance past an edge: mostly near, sometimes across the whole range.
  function automatic int spread();
    case ($urandom_range(3))
      0:       return int'($urandom_range(3));
      1:       return int'($urandom_range(63));
      2:       return int'($urandom_range(4095));
      default: return int'($urandom_range(65535));
    endcase
  endfunction

  // Build a segment around the current view so that both bisection loops
  // get plenty of work; a share stays fully random to toggle every bit.
  function automatic seg_t random_segment();
    seg_t s;
    int l, r, t, b, sx, sy, ex, ey, kind;
    s.colour = $urandom;
    kind = int'($urandom_range(99));
    if (kind < 15) begin
      s.sx = coord_t'($urandom);
      s.sy = coord_t'($urandom);
      s.ex = coord_t'($urandom);
      s.ey = coord_t'($urandom);
      return s;
    end
    l = int'(cur_left);
    r = l + int'(cur_width);
    t = int'(cur_top);
    b = t + int'(cur_height);
    sx = pick_in(l, r - l);
    sy = pick_in(t, b - t);
    // Push the start off the view now and then to exercise the drops.
    if (kind < 27) begin
      case ($urandom_range(3))
        0:       sx = l - 1 - spread();
        1:       sx = r + spread();
        2:       sy = t - 1 - spread();
        default: sy = b + spread();
      endcase
    end
    ex = pick_in(l, r - l);
    ey = pick_in(t, b - t);
    case ($urandom_range(3))
      1: ex = r + spread();
      2: ey = t - 1 - spread();
      3: begin
        ex = r + spread();
        ey = t - 1 - spread();
      end
      default: ;
    endcase
    s.sx = coord_t'(clamp_coord(sx));
    s.sy = coord_t'(clamp_coord(sy));
    s.ex = coord_t'(clamp_coord(ex));
    s.ey = coord_t'(clamp_coord(ey));
    return s;
  endfunction

  task automatic queue_seg(int sx, int sy, int ex, int ey, colour_t colour);
    seg_t s;
    s.sx = coord_t'(sx);
    s.sy = coord_t'(sy);
    s.ex = coord_t'(ex);
    s.ey = coord_t'(ey);
    s.colour = colour;
    pending_segs.push_back(s);
    segs_issued++;
  endtask

  // Write one register; call at a clock edge. The caller lowers cfg_valid
  // after the last write of a burst so that valid is never toggled in a step.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [COORD_BITS-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_VIEW_LEFT:   cur_left   = coord_t'(val);
      REG_VIEW_TOP:    cur_top    = coord_t'(val);
      REG_VIEW_WIDTH:  cur_width  = val[SIZE_BITS-1:0];
      REG_VIEW_HEIGHT: cur_height = val[SIZE_BITS-1:0];
      default: ;
    endcase
  endtask

  // Program the whole view, with a write to an unused index first.
  task automatic set_view(logic [COORD_BITS-1:0] left, logic [COORD_BITS-1:0] top,
                          logic [COORD_BITS-1:0] width, logic [COORD_BITS-1:0] height);
    write_reg(CFG_IDX_W'($urandom_range(15, 4)), COORD_BITS'($urandom));
    write_reg(REG_VIEW_LEFT, left);
    write_reg(REG_VIEW_TOP, top);
    write_reg(REG_VIEW_WIDTH, width);
    write_reg(REG_VIEW_HEIGHT, height);
    cfg_valid <= 1'b0;
  endtask

  // Wait for every queued item to be taken and every result to arrive, then
  // let any segment that ends in a drop run out of the sequencer.
  task automatic wait_drained();
    do @(posedge clk); while (segs_taken != segs_issued || clipped_expected.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Driver: offer pending items, hold each one until the block takes it, and
  // predict the clipped result at the edge of acceptance.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      holding = 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        if (clip_segment(offered_seg, predicted_seg))
          clipped_expected.push_back(predicted_seg);
        segs_taken++;
        holding = 1'b0;
      end
      if (!holding) begin
        if (pending_segs.size() != 0 && int'($urandom_range(99)) >= send_idle_pct) begin
          offered_seg = pending_segs.pop_front();
          holding = 1'b1;
          in_valid    <= 1'b1;
          start_x     <= offered_seg.sx;
          start_y     <= offered_seg.sy;
          end_x       <= offered_seg.ex;
          end_y       <= offered_seg.ey;
          line_colour <= offered_seg.colour;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Count out the long receiver hold-off once it has been armed.
  always @(posedge clk) begin
    if (long_hold_arm && hold_count < LONG_HOLD_CYCLES)
      hold_count <= hold_count + 1;
  end

  task automatic check_field(string name, longint exp_v, longint act_v);
    if (exp_v != act_v) begin
      err_count++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Monitor: compare each accepted result with the oldest prediction, then
  // decide the stall for the next cycle.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (clipped_expected.size() == 0) begin
          err_count++;
          $display("%0t: result with none expected, actual (%0d,%0d)->(%0d,%0d) colour %h",
                   $time, out_start_x, out_start_y, out_end_x, out_end_y, out_colour);
        end else begin
          expected_seg = clipped_expected.pop_front();
          check_field("out_start_x", longint'(expected_seg.sx), longint'(out_start_x));
          check_field("out_start_y", longint'(expected_seg.sy), longint'(out_start_y));
          check_field("out_end_x", longint'(expected_seg.ex), longint'(out_end_x));
          check_field("out_end_y", longint'(expected_seg.ey), longint'(out_end_y));
          check_field("out_colour", longint'(expected_seg.colour), longint'(out_colour));
        end
      end
      out_stall <= (long_hold_arm && hold_count < LONG_HOLD_CYCLES) ||
                   (int'($urandom_range(99)) < recv_idle_pct);
    end
  end

  // Give up if the run hangs.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL midpoint_line_clipper_core");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence: reset, directed items, then random phases over several views.
  // ---------------------------------------------------------------------------
  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Views straight out of reset are empty: every segment must drop.
    queue_seg(0, 0, 0, 0, 32'h0000_0000);
    queue_seg(-1, -1, 1, 1, 32'hFFFF_FFFF);
    queue_seg(32767, -32768, -32768, 32767, 32'h1234_5678);
    wait_drained();

    // View x in [-100, 539], y in [-50, 429].
    set_view(-16'sd100, -16'sd50, 16'd640, 16'd480);
    queue_seg(0, 0, 100, 100, 32'h0000_0000);              // wholly inside
    queue_seg(0, 0, 1000, 200, 32'hFFFF_FFFF);             // right edge clip
    queue_seg(10, 100, 50, -300, 32'h5555_5555);           // top edge clip
    queue_seg(500, 400, 32767, -32768, 32'hAAAA_AAAA);     // both edges
    queue_seg(600, 0, 700, 10, 32'h0000_0001);             // wholly right
    queue_seg(0, -60, 10, -100, 32'h8000_0000);            // wholly above
    queue_seg(-200, 0, 10, 10, 32'hDEAD_BEEF);             // start left of view
    queue_seg(0, 500, 10, 10, 32'h0F0F_0F0F);              // start below view
    queue_seg(5, -50, 5, -51, 32'hF0F0_F0F0);              // top bisection stalls
    queue_seg(-32768, -32768, 32767, 32767, 32'h7FFF_FFFF);
    queue_seg(32767, 32767, -32768, -32768, 32'hC3C3_C3C3);
    queue_seg(-100, -50, 539, 429, 32'h3C3C_3C3C);         // opposite corners
    queue_seg(539, 429, -100, -50, 32'h0000_FFFF);
    queue_seg(-100, -50, 540, -51, 32'hFFFF_0000);         // one past each edge
    queue_seg(0, 0, 0, 0, 32'h0101_0101);                  // single point
    queue_seg(539, 0, 32767, 0, 32'h8080_8080);            // start on last column
    queue_seg(0, -50, 0, -32768, 32'h2468_ACE0);           // start on top row
    queue_seg(-100, 429, 32767, -32768, 32'h1357_9BDF);
    wait_drained();

    for (int phase = 0; phase < PHASE_COUNT; phase++) begin
      case (phase)
        0: set_view(-16'sd32768, -16'sd32768, 16'd32767, 16'd32767);
        // Bottom-right corner of the coordinate space; width with the spare bit set.
        2: set_view(16'sd32767, 16'sd32767, 16'hFFFF, 16'd32767);
        3: set_view(COORD_BITS'($urandom), COORD_BITS'($urandom), 16'd1, 16'd1);
        4: set_view(COORD_BITS'($urandom_range(4000) - 2000),
                    COORD_BITS'($urandom_range(4000) - 2000), 16'd0,
                    COORD_BITS'($urandom_range(2000)));
        5: set_view(COORD_BITS'($urandom), COORD_BITS'($urandom),
                    COORD_BITS'($urandom), COORD_BITS'($urandom));
        7: set_view(-16'sd32768, 16'sd0, 16'd32767, 16'h8000 | 16'd32767);
        default: set_view(COORD_BITS'($urandom_range(4000) - 2000),
                          COORD_BITS'($urandom_range(4000) - 2000),
                          COORD_BITS'($urandom_range(2000, 1)),
                          COORD_BITS'($urandom_range(2000, 1)));
      endcase

      // Sender idles lightly and the receiver heavily, then swap, then run flat out.
      if (phase < 3) begin
        send_idle_pct <= 33;
        recv_idle_pct <= 56;
      end else if (phase < 6) begin
        send_idle_pct <= 56;
        recv_idle_pct <= 33;
      end else begin
        send_idle_pct <= 0;
        recv_idle_pct <= 0;
      end
      // Hold off the receiver for a long stretch so the block backs up.
      if (phase == 1) long_hold_arm <= 1'b1;
      @(posedge clk);

      for (int k = 0; k < PHASE_ITEMS; k++) begin
        pending_segs.push_back(random_segment());
        segs_issued++;
      end
      wait_drained();
    end

    if (err_count == 0) begin
      $display("PASS midpoint_line_clipper_core");
    end else begin
      $display("FAIL midpoint_line_clipper_core");
    end
    $finish;
  end

endmodule
